[rtl/pod_pkg.sv]
// Shared types and constants for the page ownership directory.
package pod_pkg;

  localparam int PAGES   = 1024;
  localparam int CLIENTS = 16;
  localparam int PAGE_W  = 10;
  localparam int ID_W    = 4;
  localparam int MODE_W  = 2;
  localparam int KIND_W  = 3;

  // request modes
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ACK   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_GRANT     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INVAL     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FWD_READ  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FWD_WRITE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RETRY     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_ACK_OK    = 3'd5;
  localparam logic [KIND_W-1:0] KIND_ACK_BAD   = 3'd6;

  // one queued request
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PAGE_W-1:0] page;
    logic [ID_W-1:0]   cli;
  } item_t;

  // one directory entry
  typedef struct packed {
    logic               valid;
    logic [ID_W-1:0]    owner;
    logic [CLIENTS-1:0] copyset;
    logic               busy;
  } rec_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic  avail;
    item_t item;
  } queue_head_t;

  // back end status toward the front end
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

endpackage

[rtl/page_ownership_directory.sv]
// Top level of the page ownership directory.
//
//  channel   signals                                     transfer when
//  request   start, mode, page_index, client_id          start && !busy
//  result    valid, kind, dest_client, page_out,         valid (one cycle)
//            requester, last
//
// A queued request goes through the back end as a pop with memory read, then
// lookup and update; a write to an owned page then walks its readers,
// one invalidation per cycle from the single-port walk, then the forward.
// The front queue holds 2 requests; busy is high while it is full.
// After reset busy stays high while every directory entry is cleared.
// Results cannot be stalled; each shows for exactly one cycle.
module page_ownership_directory (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [pod_pkg::MODE_W-1:0]  mode,
  input  logic [pod_pkg::PAGE_W-1:0]  page_index,
  input  logic [pod_pkg::ID_W-1:0]    client_id,
  output logic                        valid,
  output logic [pod_pkg::KIND_W-1:0]  kind,
  output logic [pod_pkg::ID_W-1:0]    dest_client,
  output logic [pod_pkg::PAGE_W-1:0]  page_out,
  output logic [pod_pkg::ID_W-1:0]    requester,
  output logic                        last
);
  import pod_pkg::*;

  queue_head_t head;
  back_stat_t  stat;

  pod_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .mode       (mode),
    .page_index (page_index),
    .client_id  (client_id),
    .busy       (busy),
    .head       (head),
    .stat       (stat)
  );

  pod_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .stat        (stat),
    .valid       (valid),
    .kind        (kind),
    .dest_client (dest_client),
    .page_out    (page_out),
    .requester   (requester),
    .last        (last)
  );

endmodule

[rtl/pod_front.sv]
// Front end: accepts requests, drops unused mode, queues them for the back end.
module pod_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pod_pkg::MODE_W-1:0]  mode,
  input  logic [pod_pkg::PAGE_W-1:0]  page_index,
  input  logic [pod_pkg::ID_W-1:0]    client_id,
  output logic                        busy,
  output pod_pkg::queue_head_t        head,
  input  pod_pkg::back_stat_t         stat
);
  import pod_pkg::*;

  item_t      q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;
  logic       push;

  // take a request when not clearing and queue has room
  assign busy   = stat.clearing || (count == 2'd2);
  assign accept = start && !busy;
  assign push   = accept && (mode != MODE_NONE);

  assign head.avail = (count != 2'd0);
  assign head.item  = q[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{mode: mode, page: page_index, cli: client_id};
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (stat.pop) rd_ptr <= ~rd_ptr;
      case ({push, stat.pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/pod_back.sv]
// Back end: directory memory, lookup/update sequencer and invalidation walk.
module pod_back (
  input  logic                        clk,
  input  logic                        rst,
  input  pod_pkg::queue_head_t        head,
  output pod_pkg::back_stat_t         stat,
  output logic                        valid,
  output logic [pod_pkg::KIND_W-1:0]  kind,
  output logic [pod_pkg::ID_W-1:0]    dest_client,
  output logic [pod_pkg::PAGE_W-1:0]  page_out,
  output logic [pod_pkg::ID_W-1:0]    requester,
  output logic                        last
);
  import pod_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;

  rec_t               mem [PAGES];
  rec_t               rdata;
  logic               we;
  logic [PAGE_W-1:0]  waddr;
  rec_t               wdata;

  logic               clearing;
  logic [PAGE_W-1:0]  clr_cnt;

  logic [1:0]         state;
  logic [1:0]         state_next;
  item_t              cur;
  logic [CLIENTS-1:0] walk_set;
  logic [CLIENTS-1:0] walk_set_next;
  logic [ID_W-1:0]    old_owner;
  logic [ID_W-1:0]    low_id;
  logic               pop;

  logic               emit;
  logic [KIND_W-1:0]  emit_kind;
  logic [ID_W-1:0]    emit_dest;
  logic [ID_W-1:0]    emit_req;
  logic               emit_last;
  logic [CLIENTS-1:0] cli_bit;

  assign pop           = (state == S_IDLE) && !clearing && head.avail;
  assign stat.pop      = pop;
  assign stat.clearing = clearing;

  // clearing pass over every entry after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      if (clr_cnt == PAGE_W'(PAGES - 1)) clearing <= 1'b0;
      else clr_cnt <= clr_cnt + PAGE_W'(1);
    end
  end

  // directory memory, registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (pop) rdata <= mem[head.item.page];
  end

  // lowest reader still to invalidate
  always_comb begin
    low_id = '0;
    for (int i = CLIENTS - 1; i >= 0; i--) begin
      if (walk_set[i]) low_id = ID_W'(i);
    end
  end

  // requester bit, ids past the client count never join
  always_comb begin
    cli_bit = '0;
    if (32'(cur.cli) < CLIENTS) cli_bit = CLIENTS'(1) << cur.cli;
  end

  // sequencer decode
  always_comb begin
    state_next    = state;
    walk_set_next = walk_set;
    we            = 1'b0;
    waddr         = cur.page;
    wdata         = rdata;
    emit          = 1'b0;
    emit_kind     = KIND_GRANT;
    emit_dest     = cur.cli;
    emit_req      = cur.cli;
    emit_last     = 1'b1;
    if (clearing) begin
      we    = 1'b1;
      waddr = clr_cnt;
      wdata = '0;
    end
    case (state)
      S_IDLE: begin
        if (pop) state_next = S_LOOK;
      end
      S_LOOK: begin
        state_next = S_IDLE;
        emit       = 1'b1;
        if (cur.mode == MODE_ACK) begin
          if (rdata.valid && rdata.owner == cur.cli) begin
            emit_kind  = KIND_ACK_OK;
            we         = 1'b1;
            wdata.busy = 1'b0;
          end else begin
            emit_kind = KIND_ACK_BAD;
          end
        end else if (rdata.busy) begin
          emit_kind = KIND_RETRY;
        end else if (!rdata.valid) begin
          emit_kind   = KIND_GRANT;
          we          = 1'b1;
          wdata.valid = 1'b1;
          wdata.owner = cur.cli;
        end else if (cur.mode == MODE_READ) begin
          emit_kind     = KIND_FWD_READ;
          emit_dest     = rdata.owner;
          we            = 1'b1;
          wdata.copyset = rdata.copyset | cli_bit;
        end else begin
          // write: take ownership now, then walk the readers
          emit          = 1'b0;
          we            = 1'b1;
          wdata.owner   = cur.cli;
          wdata.copyset = '0;
          wdata.busy    = 1'b1;
          walk_set_next = rdata.copyset;
          state_next    = S_WALK;
        end
      end
      S_WALK: begin
        emit = 1'b1;
        if (walk_set != '0) begin
          emit_kind     = KIND_INVAL;
          emit_dest     = low_id;
          emit_req      = '0;
          emit_last     = 1'b0;
          walk_set_next = walk_set & (walk_set - CLIENTS'(1));
        end else begin
          emit_kind  = KIND_FWD_WRITE;
          emit_dest  = old_owner;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      valid <= emit;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop) cur <= head.item;
    if (state == S_LOOK) old_owner <= rdata.owner;
    walk_set <= walk_set_next;
    if (emit) begin
      kind        <= emit_kind;
      dest_client <= emit_dest;
      page_out    <= cur.page;
      requester   <= emit_req;
      last        <= emit_last;
    end
  end

endmodule

[rtl/pod_checker.sv]
// Port-level checks for the page ownership directory, bound to the top level.
module pod_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        busy,
  input logic                        valid,
  input logic [pod_pkg::KIND_W-1:0]  kind,
  input logic [pod_pkg::ID_W-1:0]    dest_client,
  input logic [pod_pkg::ID_W-1:0]    requester,
  input logic                        last
);
  import pod_pkg::*;

  // clearing pass keeps requests out right after reset
  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  // no undefined result kind
  a_kind_known: assert property (@(posedge clk) disable iff (rst)
    valid |-> kind <= KIND_ACK_BAD)
    else $error("undefined result kind");

  // only invalidations are followed by more results
  a_last_rule: assert property (@(posedge clk) disable iff (rst)
    valid |-> ((kind == KIND_INVAL) == !last))
    else $error("last marker wrong for kind");

  // invalidations carry no requester
  a_inval_req: assert property (@(posedge clk) disable iff (rst)
    valid && kind == KIND_INVAL |-> requester == '0)
    else $error("invalidation with requester");

  // direct answers go back to the sender
  a_reply_dest: assert property (@(posedge clk) disable iff (rst)
    valid && (kind == KIND_GRANT || kind == KIND_RETRY || kind == KIND_ACK_OK ||
              kind == KIND_ACK_BAD) |-> dest_client == requester)
    else $error("direct answer not sent to requester");

endmodule

bind page_ownership_directory pod_checker u_pod_checker (.*);
